// ----- rtl/extent_read_burst_splitter_core_defines.svh -----
// ----------------------------------------------------------------------------
// Extent read burst splitter assertion macros
// Shared concurrent assertion forms for the burst splitter RTL.
// ----------------------------------------------------------------------------
`ifndef EXTENT_READ_BURST_SPLITTER_CORE_DEFINES_SVH
`define EXTENT_READ_BURST_SPLITTER_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define ERBS_ASSERT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("burst splitter assertion failed");

// Next-cycle implication, disabled while reset is held.
`define ERBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("burst splitter assertion failed");

`endif

// ----- rtl/erbs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Extent read burst splitter package
// Constants, word types and codes shared by the burst splitter modules.
// ----------------------------------------------------------------------------
package erbs_pkg;

    localparam int ADDR_BITS       = 48;
    localparam int BATCH_BEATS     = 8;
    localparam int BEAT_BYTES_LOG2 = 3;
    localparam int PAGE_SHIFT      = 12;
    localparam int LEN_HIGH_SHIFT  = 32;

    localparam int INFO_W     = 32;
    localparam int DATA_W     = 64;
    localparam int REQ_BEATS_W = 4;
    localparam int BEAT_LEN_W = 4;
    localparam int CNT_W      = 32;
    localparam int LEN_W      = ADDR_BITS + 1;
    localparam int BEAT_BYTES = 1 << BEAT_BYTES_LOG2;
    localparam int BATCH_BYTES = BATCH_BEATS << BEAT_BYTES_LOG2;
    localparam int NUM_W      = $clog2(BATCH_BEATS + 1);

    typedef enum logic [1:0] {
        KIND_INFO  = 2'd0,
        KIND_SLOT  = 2'd1,
        KIND_RESP  = 2'd2,
        KIND_RESET = 2'd3
    } t_in_kind;

    typedef enum logic [1:0] {
        OUT_REQ    = 2'd0,
        OUT_BEAT   = 2'd1,
        OUT_REJECT = 2'd2
    } t_out_kind;

    typedef struct packed {
        t_in_kind            kind;
        logic [INFO_W-1:0]   info_word;
        logic [DATA_W-1:0]   resp_data;
    } t_in_item;

    typedef struct packed {
        t_out_kind              out_kind;
        logic [ADDR_BITS-1:0]   req_addr;
        logic [REQ_BEATS_W-1:0] req_beats;
        logic [DATA_W-1:0]      beat_data;
        logic                   beat_last;
        logic [BEAT_LEN_W-1:0]  beat_len;
    } t_out_item;

    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_step_res;

endpackage

// ----- rtl/erbs_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Extent read burst splitter control
// Holds the extent state and turns one registered word into at most one
// result word in a single pass.
// ----------------------------------------------------------------------------
module erbs_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  erbs_pkg::t_in_item i_item,
    output erbs_pkg::t_step_res o_res
);
    import erbs_pkg::*;

    logic                 r_active,        n_active;
    logic [1:0]           r_info_count,    n_info_count;
    logic [ADDR_BITS-1:0] r_next_addr,     n_next_addr;
    logic [LEN_W-1:0]     r_total_len,     n_total_len;
    logic [LEN_W-1:0]     r_bytes_left,    n_bytes_left;
    logic [CNT_W-1:0]     r_beats_issued,  n_beats_issued;
    logic [CNT_W-1:0]     r_beats_recv,    n_beats_recv;
    logic                 r_issuing_done,  n_issuing_done;

    logic [NUM_W-1:0]     v_num;
    logic [LEN_W-1:0]     v_round;
    logic [LEN_W-1:0]     v_rem;
    logic [ADDR_BITS-1:0] v_page;
    t_step_res            v_res;

    always_comb begin
        n_active       = r_active;
        n_info_count   = r_info_count;
        n_next_addr    = r_next_addr;
        n_total_len    = r_total_len;
        n_bytes_left   = r_bytes_left;
        n_beats_issued = r_beats_issued;
        n_beats_recv   = r_beats_recv;
        n_issuing_done = r_issuing_done;
        v_res          = '0;
        v_num          = '0;
        v_round        = r_bytes_left + LEN_W'(BEAT_BYTES - 1);
        v_rem          = r_total_len & LEN_W'(BEAT_BYTES - 1);
        v_page         = {{(ADDR_BITS - INFO_W){1'b0}}, i_item.info_word} << PAGE_SHIFT;

        case (i_item.kind)
            KIND_INFO: begin
                if (r_active) begin
                    v_res.valid         = 1'b1;
                    v_res.item.out_kind = OUT_REJECT;
                end else begin
                    n_info_count = r_info_count + 2'd1;
                    case (n_info_count)
                        2'd1: begin
                            n_next_addr = v_page;
                        end
                        2'd2: begin
                            n_total_len = {{(LEN_W - INFO_W){1'b0}}, i_item.info_word};
                        end
                        2'd3: begin
                            // Third word completes the length and starts the extent.
                            n_total_len    = {r_total_len[LEN_W-LEN_HIGH_SHIFT-1:0],
                                              i_item.info_word};
                            n_bytes_left   = {r_total_len[LEN_W-LEN_HIGH_SHIFT-1:0],
                                              i_item.info_word};
                            n_active       = 1'b1;
                            n_issuing_done = 1'b0;
                            n_beats_issued = '0;
                            n_beats_recv   = '0;
                            n_info_count   = 2'd0;
                        end
                        default: begin
                            n_info_count = 2'd0;
                        end
                    endcase
                end
            end
            KIND_SLOT: begin
                if (r_active && (r_bytes_left != '0)) begin
                    if (r_bytes_left > LEN_W'(BATCH_BYTES)) begin
                        v_num        = NUM_W'(BATCH_BEATS);
                        n_bytes_left = r_bytes_left - LEN_W'(BATCH_BYTES);
                    end else begin
                        // Final request: round the remainder up to whole beats.
                        v_num          = NUM_W'(v_round >> BEAT_BYTES_LOG2);
                        n_bytes_left   = '0;
                        n_issuing_done = 1'b1;
                    end
                    v_res.valid          = 1'b1;
                    v_res.item.out_kind  = OUT_REQ;
                    v_res.item.req_addr  = r_next_addr;
                    v_res.item.req_beats = REQ_BEATS_W'(v_num);
                    n_next_addr    = r_next_addr + (ADDR_BITS'(v_num) << BEAT_BYTES_LOG2);
                    n_beats_issued = r_beats_issued + CNT_W'(v_num);
                end
            end
            KIND_RESP: begin
                if (r_active) begin
                    n_beats_recv         = r_beats_recv + CNT_W'(1);
                    v_res.valid          = 1'b1;
                    v_res.item.out_kind  = OUT_BEAT;
                    v_res.item.beat_data = i_item.resp_data;
                    v_res.item.beat_len  = BEAT_LEN_W'(BEAT_BYTES);
                    if ((r_beats_issued == n_beats_recv) && r_issuing_done) begin
                        v_res.item.beat_last = 1'b1;
                        if (v_rem != '0) begin
                            v_res.item.beat_len = BEAT_LEN_W'(v_rem);
                        end
                        n_active = 1'b0;
                    end
                end
            end
            KIND_RESET: begin
                n_active       = 1'b0;
                n_info_count   = 2'd0;
                n_next_addr    = '0;
                n_total_len    = '0;
                n_bytes_left   = '0;
                n_beats_issued = '0;
                n_beats_recv   = '0;
                n_issuing_done = 1'b0;
            end
            default: begin
                v_res = '0;
            end
        endcase
    end

    assign o_res = v_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active       <= 1'b0;
            r_info_count   <= 2'd0;
            r_next_addr    <= '0;
            r_total_len    <= '0;
            r_bytes_left   <= '0;
            r_beats_issued <= '0;
            r_beats_recv   <= '0;
            r_issuing_done <= 1'b0;
        end else if (i_fire) begin
            r_active       <= n_active;
            r_info_count   <= n_info_count;
            r_next_addr    <= n_next_addr;
            r_total_len    <= n_total_len;
            r_bytes_left   <= n_bytes_left;
            r_beats_issued <= n_beats_issued;
            r_beats_recv   <= n_beats_recv;
            r_issuing_done <= n_issuing_done;
        end
    end

endmodule

// ----- rtl/extent_read_burst_splitter_core.sv -----
`timescale 1ns / 1ps
// Flow: a word accepted sits in the input register, and its result word is
// loaded into the output register by one pass, held while the output stalls.
// Throughput: one word per cycle; the output register stalls the input only
// when it is full and its word is not taken.
// Reset: i_rst_n synchronous, active low, clears the extent state and both
// valid flags; a reset word on the input does the same to the state.
// ----------------------------------------------------------------------------
// Extent read burst splitter core
// Splits an extent into bounded read requests and forwards response beats
// with byte lengths and a last mark.
// ----------------------------------------------------------------------------
`include "extent_read_burst_splitter_core_defines.svh"

module extent_read_burst_splitter_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  erbs_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output erbs_pkg::t_out_item o_out
);
    import erbs_pkg::*;

    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    logic      s1_adv;
    logic      s1_fire;
    t_step_res s1_res;

    // The pass may proceed when the output register is empty or being emptied.
    assign s1_adv     = !r_out_valid || !i_out_stall;
    assign s1_fire    = r_in_valid && s1_adv;
    assign o_in_stall = r_in_valid && !s1_adv;

    erbs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (s1_fire),
        .i_item  (r_in),
        .o_res   (s1_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (s1_adv) begin
                r_out_valid <= s1_fire && s1_res.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in;
        end
        if (s1_fire && s1_res.valid) begin
            r_out <= s1_res.item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `ERBS_ASSERT_NEXT(a_in_held, i_clk, i_rst_n, o_in_stall, r_in_valid && $stable(r_in))
    `ERBS_ASSERT(a_beat_len, i_clk, i_rst_n, o_out_valid && (o_out.out_kind == OUT_BEAT), (o_out.beat_len != '0) && (o_out.beat_len <= BEAT_LEN_W'(BEAT_BYTES)))
    `ERBS_ASSERT(a_req_beats, i_clk, i_rst_n, o_out_valid && (o_out.out_kind == OUT_REQ), o_out.req_beats != '0)
    `ERBS_ASSERT(a_stall_src, i_clk, i_rst_n, o_in_stall, r_out_valid && i_out_stall)

endmodule
